FILE: hdl/lic_pkg.sv
package lic_pkg;

    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_GET      = 2'd1,
        CMD_EVICT    = 2'd2,
        CMD_CONTAINS = 2'd3
    } cmd_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    localparam logic [4:0] CAPACITY_RESET = 5'd16;

    typedef struct packed {
        cmd_t        command;
        logic [63:0] key_upper;
        logic [63:0] key_middle;
        logic [31:0] key_lower;
        logic [63:0] payload_in;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [63:0] payload_out;
        logic [4:0]  occupancy;
    } rsp_t;

    // Controller to datapath step strobes
    typedef struct packed {
        logic load_req;
        logic do_match;
        logic do_find;
        logic do_read;
        logic do_apply;
        logic load_rsp;
    } ctl_t;

endpackage

FILE: hdl/lru_id_cache_top.sv
// A request is registered, then runs through the compare, priority pick, slot read and
// shift/update steps one after another in the controller sequence before the response
// register is loaded; no new command is taken until the sequence is back in idle.
// A new request is taken while the previous response still waits to be taken.
// Reset (rst_n, async, active low) empties the cache and sets capacity to 16.
module lru_id_cache_top
#(
    parameter int SLOTS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  lic_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output lic_pkg::rsp_t rsp,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [4:0]    cfg_data
);

    lic_pkg::ctl_t ctl;

    assign cfg_ready = 1'b1;

    lic_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .ctl       (ctl)
    );

    lic_datapath #(.SLOTS(SLOTS)) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .rsp       (rsp)
    );

endmodule

FILE: hdl/lic_ctrl.sv
module lic_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output lic_pkg::ctl_t ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_FIND,
        S_READ,
        S_APPLY,
        S_DONE
    } state_t;

    state_t state_reg;
    logic   rsp_valid_reg;
    logic   rsp_load;

    // Result register may be refilled in the same cycle it is taken
    assign rsp_load = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        ctl          = '0;
        ctl.load_req = (state_reg == S_IDLE) && req_valid;
        ctl.do_match = (state_reg == S_MATCH);
        ctl.do_find  = (state_reg == S_FIND);
        ctl.do_read  = (state_reg == S_READ);
        ctl.do_apply = (state_reg == S_APPLY);
        ctl.load_rsp = rsp_load;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                        state_reg <= S_MATCH;
                end
                S_MATCH: state_reg <= S_FIND;
                S_FIND:  state_reg <= S_READ;
                S_READ:  state_reg <= S_APPLY;
                S_APPLY: state_reg <= S_DONE;
                S_DONE:
                begin
                    if (rsp_load)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: hdl/lic_datapath.sv
module lic_datapath
#(
    parameter int SLOTS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  lic_pkg::ctl_t ctl,
    input  lic_pkg::req_t req,
    input  logic          cfg_valid,
    input  logic [4:0]    cfg_data,
    output lic_pkg::rsp_t rsp
);

    localparam int CW = $clog2(SLOTS + 1);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW = (CW > 5) ? CW : 5;

    typedef struct packed {
        logic [63:0] key_upper;
        logic [63:0] key_middle;
        logic [31:0] key_lower;
        logic [63:0] payload;
    } slot_t;

    slot_t         slot_reg [SLOTS];
    lic_pkg::req_t req_reg;
    logic [4:0]    cap_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [SLOTS-1:0] match_reg;
    logic [SLOTS-1:0] match_next;
    logic          hit_reg;
    logic          hit_next;
    logic [IW-1:0] hit_idx_reg;
    logic [IW-1:0] hit_idx_next;
    logic [63:0]   rd_payload_reg;
    logic [IW-1:0] rd_addr;
    lic_pkg::rsp_t res_reg;
    lic_pkg::rsp_t res_next;
    lic_pkg::rsp_t rsp_reg;
    logic [SLOTS-1:0] shift_mask;
    slot_t         front;
    logic [LW-1:0] limit;
    logic          full;

    // Tag compare in every live slot
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            match_next[i] = (CW'(i) < count_reg)
                && (slot_reg[i].key_upper == req_reg.key_upper)
                && (slot_reg[i].key_middle == req_reg.key_middle)
                && (slot_reg[i].key_lower == req_reg.key_lower);
        end
    end

    // Lowest matching slot is the most recent one
    always_comb
    begin
        hit_idx_next = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (match_reg[i])
                hit_idx_next = IW'(i);
        end
        hit_next = |match_reg;
    end

    assign rd_addr = (req_reg.command == lic_pkg::CMD_GET) ? hit_idx_reg
                                                            : IW'(count_reg - 1'b1);

    assign limit = (LW'(cap_reg) < LW'(SLOTS)) ? LW'(cap_reg) : LW'(SLOTS);
    assign full  = (LW'(count_reg) >= limit);

    always_comb
    begin
        count_next = count_reg;
        res_next   = '0;
        shift_mask = '0;
        front.key_upper  = req_reg.key_upper;
        front.key_middle = req_reg.key_middle;
        front.key_lower  = req_reg.key_lower;
        front.payload    = req_reg.payload_in;

        unique case (req_reg.command)
            lic_pkg::CMD_ADD:
            begin
                if (full)
                    res_next.status = lic_pkg::ST_NOSPACE;
                else
                begin
                    count_next = count_reg + 1'b1;
                    shift_mask = '1;
                end
            end
            lic_pkg::CMD_GET:
            begin
                front.payload = rd_payload_reg;
                if (hit_reg)
                begin
                    res_next.found       = 1'b1;
                    res_next.payload_out = rd_payload_reg;
                    for (int i = 0; i < SLOTS; i++)
                        shift_mask[i] = (IW'(i) <= hit_idx_reg);
                end
            end
            lic_pkg::CMD_EVICT:
            begin
                if (count_reg == '0)
                    res_next.status = lic_pkg::ST_EMPTY;
                else
                begin
                    count_next           = count_reg - 1'b1;
                    res_next.payload_out = rd_payload_reg;
                end
            end
            lic_pkg::CMD_CONTAINS:
            begin
                res_next.found = hit_reg;
            end
            default:
            begin
                res_next.status = lic_pkg::ST_OK;
            end
        endcase

        res_next.occupancy = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= lic_pkg::CAPACITY_RESET;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
                cap_reg <= cfg_data;
            if (ctl.do_apply)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_req)
            req_reg <= req;
        if (ctl.do_match)
            match_reg <= match_next;
        if (ctl.do_find)
        begin
            hit_reg     <= hit_next;
            hit_idx_reg <= hit_idx_next;
        end
        if (ctl.do_read)
            rd_payload_reg <= slot_reg[rd_addr].payload;
        if (ctl.do_apply)
        begin
            res_reg <= res_next;
            if (shift_mask[0])
                slot_reg[0] <= front;
            for (int i = 1; i < SLOTS; i++)
            begin
                if (shift_mask[i])
                    slot_reg[i] <= slot_reg[i-1];
            end
        end
        if (ctl.load_rsp)
            rsp_reg <= res_reg;
    end

    assign rsp = rsp_reg;

endmodule

FILE: hdl/lic_checker.sv
module lic_checker
#(
    parameter int SLOTS = 16
)
(
    input logic          clk,
    input logic          rst_n,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input lic_pkg::rsp_t rsp
);

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (SLOTS > 31) || (rsp.occupancy <= SLOTS))
        else $error("occupancy beyond slot count");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.found |-> rsp.status == lic_pkg::ST_OK)
        else $error("hit reported with error status");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != lic_pkg::ST_OK)
        |-> !rsp.found && (rsp.payload_out == '0))
        else $error("error response carries data");

endmodule

bind lru_id_cache_top lic_checker #(.SLOTS(SLOTS)) u_lic_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
